// File: hw/rtl/sfq_pkg.sv
// Shared constants and types for the symmetric Q15 FIR filter.
package sfq_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int TAP_W         = 16;
  localparam int PRESUM_W      = SAMPLE_W + 1;
  localparam int PROD_W        = PRESUM_W + TAP_W;
  localparam int DATA_W        = 64;
  localparam int TAP_WORDS     = 4;
  localparam int TAPS_PER_WORD = DATA_W / TAP_W;
  localparam int REG_IDX_LSB   = 3;
  localparam int ADDR_W        = REG_IDX_LSB + $clog2(TAP_WORDS);

  localparam int TAP_COUNT_DEFAULT = 16;
  localparam int HDL_DELAY_DEFAULT = 4;

  // Output scaling: divide by 32767 after a signed remainder modulo 32768*32767.
  localparam int SCALE_DIV    = 32767;
  localparam int ROUND_BIAS   = (SCALE_DIV - 1) / 2;
  localparam int WRAP_MOD     = 32768 * SCALE_DIV;
  localparam int FOLD_SHIFT   = 30;
  localparam int FOLD_GAIN    = 15;
  localparam int FOLD_W       = FOLD_SHIFT + 1;
  localparam int QUOT_SHIFT   = 15;
  localparam int SCALE_STAGES = 5;

  typedef struct packed {
    logic shift;
    logic advance;
  } sfq_ctrl_t;

endpackage

// File: hw/rtl/sfq_tap_cell.sv
// One cell of the folded delay line: two samples, a pre-add and a tap multiply.
module sfq_tap_cell import sfq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  sfq_ctrl_t                  ctrl,
  input  logic signed [TAP_W-1:0]    tap,
  input  logic signed [SAMPLE_W-1:0] fwd_in,
  input  logic signed [SAMPLE_W-1:0] back_in,
  output logic signed [SAMPLE_W-1:0] fwd_out,
  output logic signed [SAMPLE_W-1:0] back_out,
  output logic signed [PROD_W-1:0]   prod
);

  logic signed [SAMPLE_W-1:0] fwd;
  logic signed [SAMPLE_W-1:0] back;
  logic signed [PRESUM_W-1:0] presum;
  logic signed [PROD_W-1:0]   mult;

  // The product uses the line contents after this cycle's shift.
  assign presum = PRESUM_W'(fwd_in) + PRESUM_W'(back_in);
  assign mult   = PROD_W'(tap) * PROD_W'(presum);

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd  <= '0;
      back <= '0;
    end else if (ctrl.shift) begin
      fwd  <= fwd_in;
      back <= back_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      prod <= mult;
    end
  end

  assign fwd_out  = fwd;
  assign back_out = back;

endmodule

// File: hw/rtl/sfq_add_tree.sv
// Registered binary adder tree over the cell products.
module sfq_add_tree import sfq_pkg::*; #(
  parameter int NUM_IN = TAP_COUNT_DEFAULT,
  parameter int IN_W   = PROD_W,
  parameter int SUM_W  = PROD_W + $clog2(TAP_COUNT_DEFAULT)
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [IN_W-1:0]  terms [NUM_IN],
  output logic signed [SUM_W-1:0] sum
);

  localparam int LEVELS = $clog2(NUM_IN);
  localparam int LEAVES = 1 << LEVELS;

  logic signed [SUM_W-1:0] leaf [LEAVES];
  logic signed [SUM_W-1:0] node [LEAVES-1];

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < NUM_IN) begin : g_used
      assign leaf[j] = SUM_W'(terms[j]);
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  // Heap order: node i adds children 2i+1 and 2i+2; the bottom row reads the leaves.
  for (genvar i = 0; i < LEAVES - 1; i++) begin : g_node
    logic signed [SUM_W-1:0] lhs;
    logic signed [SUM_W-1:0] rhs;
    if (2 * i + 1 >= LEAVES - 1) begin : g_bottom
      assign lhs = leaf[2 * i + 1 - (LEAVES - 1)];
      assign rhs = leaf[2 * i + 2 - (LEAVES - 1)];
    end else begin : g_inner
      assign lhs = node[2 * i + 1];
      assign rhs = node[2 * i + 2];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        node[i] <= lhs + rhs;
      end
    end
  end

  assign sum = node[0];

endmodule

// File: hw/rtl/sfq_scale.sv
// Pipelined output scaling: signed remainder, rounded divide by 32767, 16-bit wrap.
module sfq_scale import sfq_pkg::*; #(
  parameter int SUM_W = PROD_W + $clog2(TAP_COUNT_DEFAULT)
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [SUM_W-1:0]    sum,
  output logic signed [SAMPLE_W-1:0] y
);

  logic [SUM_W-1:0]      mag;
  logic                  neg_a;
  logic [FOLD_W-1:0]     fold;
  logic                  neg_b;
  logic [FOLD_SHIFT-1:0] red;
  logic                  neg_c;
  logic [FOLD_SHIFT-1:0] biased;
  logic                  neg_d;
  logic [SAMPLE_W-1:0]   quot;
  logic                  neg_e;

  logic [FOLD_W-1:0]         fold_next;
  logic [FOLD_SHIFT-1:0]     red_next;
  logic [QUOT_SHIFT-1:0]     q0;
  logic [SAMPLE_W-1:0]       r0;
  logic [SAMPLE_W-1:0]       quot_next;

  // Since 2^30 is congruent to 2^15 modulo 32768*32767, the high bits fold down
  // and leave a value below twice the modulus.
  assign fold_next = (FOLD_W'(mag[SUM_W-1:FOLD_SHIFT]) << FOLD_GAIN)
                   + FOLD_W'(mag[FOLD_SHIFT-1:0]);
  assign red_next  = (fold >= FOLD_W'(WRAP_MOD)) ? FOLD_SHIFT'(fold - FOLD_W'(WRAP_MOD))
                                                 : FOLD_SHIFT'(fold);

  // Division by 2^15-1: quotient estimate from the high bits, then up to two
  // corrections from the small residue.
  assign q0        = biased[FOLD_SHIFT-1:QUOT_SHIFT];
  assign r0        = SAMPLE_W'(q0) + SAMPLE_W'(biased[QUOT_SHIFT-1:0]);
  assign quot_next = SAMPLE_W'(q0)
                   + SAMPLE_W'(r0 >= SAMPLE_W'(SCALE_DIV))
                   + SAMPLE_W'(r0 >= SAMPLE_W'(2 * SCALE_DIV));

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a  <= sum[SUM_W-1];
      mag    <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      neg_b  <= neg_a;
      fold   <= fold_next;
      neg_c  <= neg_b;
      red    <= red_next;
      neg_d  <= neg_c;
      biased <= red + FOLD_SHIFT'(ROUND_BIAS);
      neg_e  <= neg_d;
      quot   <= quot_next;
    end
  end

  assign y = neg_e ? SAMPLE_W'(-quot) : SAMPLE_W'(quot);

endmodule

// File: hw/rtl/symmetric_fir_q15_filter.sv
// Top level of the even-symmetric Q15 FIR filter with tap registers and peak hold.
//
//   Channel   Direction  Handshake                    Payload
//   input     in         in_valid / in_ready          sample_in, block_end
//   output    out        out_valid / out_ready        filt_sample, peak_value,
//                                                     block_end_out, last
//   config    in         APB write, pready always 1   paddr, pwdata / prdata
//
// The filter takes one input transaction per clock cycle while in_ready is high.
// Each sample runs through the cell row (one stage), the registered adder tree
// ($clog2(TAP_COUNT) stages) and the scaling pipeline (five stages), then the
// output register. The first transaction after reset is preceded by
// TAP_COUNT+HDL_DELAY-1 zero results, emitted one per cycle while the output is
// free; a finished result that reaches the end of the pipeline waits there
// until they have drained. Reset clears the delay line, taps, peak and control
// state. A stall on the output holds the whole pipeline once a finished result
// waits at its tail, and in_ready drops with it.
module symmetric_fir_q15_filter import sfq_pkg::*; #(
  parameter int TAP_COUNT = TAP_COUNT_DEFAULT,
  parameter int HDL_DELAY = HDL_DELAY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       block_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] filt_sample,
  output logic signed [SAMPLE_W-1:0] peak_value,
  output logic                       block_end_out,
  output logic                       last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int TREE_LEVELS = $clog2(TAP_COUNT);
  localparam int SUM_W       = PROD_W + TREE_LEVELS;
  localparam int PIPE_DEPTH  = 1 + TREE_LEVELS + SCALE_STAGES;
  localparam int ZERO_COUNT  = TAP_COUNT + HDL_DELAY - 1;
  localparam int ZC_W        = $clog2(ZERO_COUNT + 1);

  // Configuration registers: four 64-bit words of packed taps.
  logic [DATA_W-1:0] tap_word [TAP_WORDS];
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = tap_word[paddr[ADDR_W-1:REG_IDX_LSB]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAP_WORDS; i++) begin
        tap_word[i] <= '0;
      end
    end else if (cfg_write) begin
      tap_word[paddr[ADDR_W-1:REG_IDX_LSB]] <= pwdata;
    end
  end

  // Taps past the register space read as zero.
  logic signed [TAP_W-1:0] tap [TAP_COUNT];

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
    if (k < TAP_WORDS * TAPS_PER_WORD) begin : g_reg
      assign tap[k] = tap_word[k / TAPS_PER_WORD][TAP_W * (k % TAPS_PER_WORD) +: TAP_W];
    end else begin : g_zero
      assign tap[k] = '0;
    end
  end

  // Pipeline control. Everything moves together on advance; an input
  // transaction enters on the same edge.
  logic            advance;
  logic            in_accept;
  logic            out_free;
  logic            tail_valid;
  logic [ZC_W-1:0] zero_cnt;
  logic            primed;
  sfq_ctrl_t       ctrl;

  logic v_pipe  [PIPE_DEPTH];
  logic be_pipe [PIPE_DEPTH];

  assign tail_valid = v_pipe[PIPE_DEPTH-1];
  assign out_free   = !out_valid || out_ready;
  // A finished result waits at the tail while priming zeros are still draining.
  assign advance    = !tail_valid || (out_free && (zero_cnt == '0));
  assign in_ready   = advance;
  assign in_accept  = in_valid && in_ready;

  assign ctrl.shift   = in_accept;
  assign ctrl.advance = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        v_pipe[i] <= 1'b0;
      end
    end else if (advance) begin
      v_pipe[0] <= in_accept;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        v_pipe[i] <= v_pipe[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      be_pipe[0] <= block_end;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        be_pipe[i] <= be_pipe[i-1];
      end
    end
  end

  // Folded delay line: cell k holds line positions k and 2*TAP_COUNT-1-k. New
  // samples travel right along the front half and return left along the back.
  logic signed [SAMPLE_W-1:0] fwd_link  [TAP_COUNT+1];
  logic signed [SAMPLE_W-1:0] back_link [TAP_COUNT];
  logic signed [PROD_W-1:0]   prod      [TAP_COUNT];

  assign fwd_link[0] = sample_in;

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    logic signed [SAMPLE_W-1:0] back_src;
    if (k == TAP_COUNT - 1) begin : g_turn
      assign back_src = fwd_link[TAP_COUNT];
    end else begin : g_mid
      assign back_src = back_link[k+1];
    end
    sfq_tap_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .tap      (tap[k]),
      .fwd_in   (fwd_link[k]),
      .back_in  (back_src),
      .fwd_out  (fwd_link[k+1]),
      .back_out (back_link[k]),
      .prod     (prod[k])
    );
  end

  logic signed [SUM_W-1:0]    acc_sum;
  logic signed [SAMPLE_W-1:0] y;

  sfq_add_tree #(
    .NUM_IN (TAP_COUNT),
    .IN_W   (PROD_W),
    .SUM_W  (SUM_W)
  ) u_tree (
    .clk   (clk),
    .en    (advance),
    .terms (prod),
    .sum   (acc_sum)
  );

  sfq_scale #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk (clk),
    .en  (advance),
    .sum (acc_sum),
    .y   (y)
  );

  // Priming counter and peak hold.
  logic signed [SAMPLE_W-1:0] peak_hold;
  logic signed [SAMPLE_W-1:0] peak_next;

  assign peak_next = (y > peak_hold) ? y : peak_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      zero_cnt  <= '0;
      peak_hold <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept && !primed) begin
        primed   <= 1'b1;
        zero_cnt <= ZC_W'(ZERO_COUNT);
      end
      if (out_free) begin
        if (zero_cnt != '0) begin
          zero_cnt  <= zero_cnt - 1'b1;
          out_valid <= 1'b1;
        end else if (tail_valid) begin
          peak_hold <= peak_next;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (zero_cnt != '0) begin
        filt_sample   <= '0;
        peak_value    <= peak_hold;
        block_end_out <= 1'b0;
        last          <= 1'b0;
      end else if (tail_valid) begin
        filt_sample   <= y;
        peak_value    <= peak_next;
        block_end_out <= be_pipe[PIPE_DEPTH-1];
        last          <= 1'b1;
      end
    end
  end

endmodule

// File: dv/sfq_fir_checker.sv
// Checker for the symmetric Q15 FIR filter: predicts every result and compares it.
module sfq_fir_checker import sfq_pkg::*; #(
  parameter int TAP_COUNT = TAP_COUNT_DEFAULT,
  parameter int HDL_DELAY = HDL_DELAY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       block_end,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] filt_sample,
  input  logic signed [SAMPLE_W-1:0] peak_value,
  input  logic                       block_end_out,
  input  logic                       last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  input  logic                       pready,
  output int                         outstanding,
  output int                         mismatches
);

  localparam int LINE_LEN    = 2 * TAP_COUNT;
  localparam int PRIME_ZEROS = TAP_COUNT + HDL_DELAY - 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] peak;
    logic                       blk_end;
    logic                       last;
  } fir_result_t;

  logic [DATA_W-1:0]          tap_regs [TAP_WORDS];
  logic signed [SAMPLE_W-1:0] history [LINE_LEN];
  logic                       primed_q;
  logic signed [SAMPLE_W-1:0] peak_q;
  fir_result_t                filtered_q [$];
  fir_result_t                wanted;
  fir_result_t                seen;
  int                         mismatch_cnt = 0;
  int                         reg_idx;

  function automatic logic signed [TAP_W-1:0] tap_value(int t);
    if (t >= TAP_WORDS * TAPS_PER_WORD) return '0;
    return tap_regs[t / TAPS_PER_WORD][TAP_W * (t % TAPS_PER_WORD) +: TAP_W];
  endfunction

  // The second half of the coefficient row mirrors the first.
  function automatic logic signed [TAP_W-1:0] coef(int k);
    if (k < TAP_COUNT) return tap_value(k);
    return tap_value(LINE_LEN - 1 - k);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] scale_q15(longint acc);
    longint r;
    longint mag;
    longint q;
    r   = acc % longint'(WRAP_MOD);
    mag = (r < 0) ? -r : r;
    q   = (2 * mag + SCALE_DIV) / (2 * longint'(SCALE_DIV));
    if (r < 0) q = -q;
    return q[SAMPLE_W-1:0];
  endfunction

  task automatic predict_sample(logic signed [SAMPLE_W-1:0] x, logic be);
    longint                     acc;
    logic signed [SAMPLE_W-1:0] y;
    int                         k;
    if (!primed_q) begin
      for (k = 0; k < PRIME_ZEROS; k++) filtered_q.push_back('{'0, peak_q, 1'b0, 1'b0});
      primed_q = 1'b1;
    end
    for (k = LINE_LEN - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = x;
    acc = 0;
    for (k = 0; k < LINE_LEN; k++) acc += longint'(coef(k)) * longint'(history[k]);
    y = scale_q15(acc);
    if (y > peak_q) peak_q = y;
    filtered_q.push_back('{y, peak_q, be, 1'b1});
  endtask

  task automatic report_mismatch(string why);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $write("%0t: %s: expected sample %0d peak %0d end %0b last %0b",
             $realtime, why, wanted.sample, wanted.peak, wanted.blk_end, wanted.last);
      $display(", got sample %0d peak %0d end %0b last %0b",
               seen.sample, seen.peak, seen.blk_end, seen.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAP_WORDS; i++) tap_regs[i] = '0;
      for (int i = 0; i < LINE_LEN; i++) history[i] = '0;
      primed_q = 1'b0;
      peak_q   = '0;
      filtered_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        reg_idx = int'(paddr >> REG_IDX_LSB);
        if (reg_idx < TAP_WORDS) tap_regs[reg_idx] = pwdata;
      end
      if (out_valid && out_ready) begin
        seen = '{filt_sample, peak_value, block_end_out, last};
        if (filtered_q.size() == 0) begin
          wanted = 'x;
          report_mismatch("result with nothing pending");
        end else begin
          wanted = filtered_q.pop_front();
          if (seen.sample !== wanted.sample || seen.peak !== wanted.peak ||
              seen.blk_end !== wanted.blk_end || seen.last !== wanted.last)
            report_mismatch("result mismatch");
        end
      end
      if (in_valid && in_ready) predict_sample(sample_in, block_end);
    end
    outstanding <= filtered_q.size();
    mismatches  <= mismatch_cnt;
  end

endmodule

// File: dv/tb_symmetric_fir_q15_filter.sv
// Testbench top for the symmetric Q15 FIR filter: stimulus, register setup and verdict.
module tb_symmetric_fir_q15_filter import sfq_pkg::*;;

  localparam int CLK_PERIOD = 10;
  // The tail after the last result leaves room for anything the block might still emit unasked.
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       block_end = 1'b0;
  logic                       out_ready = 1'b0;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [ADDR_W-1:0]          paddr     = '0;
  logic [DATA_W-1:0]          pwdata    = '0;

  logic                       in_ready;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] filt_sample;
  logic signed [SAMPLE_W-1:0] peak_value;
  logic                       block_end_out;
  logic                       last;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  int outstanding;
  int mismatches;

  // Idling controls: each side may draw a random wait before each transaction.
  // With the flag cleared that side runs back to back.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  // A long receiver hold-off is requested by bumping hold_req; the receiver
  // process serves it once and records that in hold_done.
  int hold_req  = 0;
  int hold_done = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  symmetric_fir_q15_filter u_top (
    .clk, .rst, .in_valid, .in_ready, .sample_in, .block_end,
    .out_valid, .out_ready, .filt_sample, .peak_value, .block_end_out, .last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sfq_fir_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .sample_in, .block_end,
    .out_valid, .out_ready, .filt_sample, .peak_value, .block_end_out, .last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .outstanding, .mismatches
  );

  // Offers one sample transaction, optionally after a random gap, and returns
  // at the clock edge where it was accepted. Valid stays high on return so a
  // following back-to-back transaction does not lower it in between.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic be);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    block_end <= be;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted result has come back.
  // Every sample yields at least one result, so an empty scoreboard means
  // the pipeline holds nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One APB write: a setup cycle, then an access cycle that completes when
  // pready is seen high. The caller lowers psel after its last write.
  task automatic apb_write(int idx, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx << REG_IDX_LSB);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Loads all four tap words; word 0 sits in the low 64 bits.
  task automatic load_taps(logic [TAP_WORDS*DATA_W-1:0] words);
    for (int i = 0; i < TAP_WORDS; i++) apb_write(i, words[i*DATA_W +: DATA_W]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [TAP_WORDS*DATA_W-1:0] random_taps();
    logic [TAP_WORDS*DATA_W-1:0] w;
    for (int i = 0; i < TAP_WORDS * 2; i++) w[i*32 +: 32] = $urandom;
    return w;
  endfunction

  // Samples lean toward the rails and toward small values, where the wrap
  // and rounding of the output scaling are most likely to show up.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_W'($signed(r[6:0]));
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_sample(random_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Receiver: draws a stall per result, or serves a requested long hold-off.
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        stall     = HOLD_CYCLES;
      end else begin
        stall = rx_idle ? $urandom_range(0, 15) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Main stimulus.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Tap 0 at the negative rail and tap 1 at 2 make the second sample's sum
    // land just below the wrap modulus, so the rounded magnitude reaches 32768
    // and wraps to the negative rail. The first sample also triggers the
    // priming zeros while the peak is still at its reset value.
    load_taps({64'h0, 64'h0, 64'h0, 64'h0000_0000_0002_8000});
    send_sample(-16'sd16400, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    wait_drained();

    // Impulse at full scale followed by zeros walks the taps out one by one,
    // then the rails alternate to drive the sum to its extremes.
    load_taps({((TAP_WORDS-1)*DATA_W)'(random_taps() >> DATA_W), 64'h7FFF_8000_0001_FFFF});
    send_sample(16'sh7FFF, 1'b1);
    repeat (8) send_sample(16'sd0, 1'b0);
    for (int i = 0; i < 4; i++) begin
      send_sample(16'sh8000, 1'(i[0]));
      send_sample(16'sh7FFF, 1'(~i[0]));
    end
    wait_drained();

    // Random taps with idling on both sides.
    load_taps(random_taps());
    send_random(25);
    wait_drained();

    // All taps at the positive rail, no idling anywhere.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    load_taps({TAP_WORDS*TAPS_PER_WORD{16'h7FFF}});
    send_random(30);
    wait_drained();

    // All taps at the negative rail, only the sender idles.
    tx_idle = 1'b1;
    load_taps({TAP_WORDS*TAPS_PER_WORD{16'h8000}});
    send_random(30);
    wait_drained();

    // The receiver holds off for a long stretch while samples keep coming
    // back to back, so the pipeline fills and in_ready drops.
    tx_idle = 1'b0;
    load_taps(random_taps());
    hold_req = hold_req + 1;
    send_random(40);
    wait_drained();

    // Zero taps, then a last random setting, with idling on both sides.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_taps('0);
    send_random(15);
    wait_drained();
    load_taps(random_taps());
    send_random(20);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legitimate run.
  initial begin
    #(CLK_PERIOD * 200000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sfq_pkg.sv
hw/rtl/sfq_tap_cell.sv
hw/rtl/sfq_add_tree.sv
hw/rtl/sfq_scale.sv
hw/rtl/symmetric_fir_q15_filter.sv
dv/sfq_fir_checker.sv
dv/tb_symmetric_fir_q15_filter.sv
